>>> src/line_rasterizer_macros.svh
// Assertion macros for the line rasterizer.
// Each macro expects a clock named clk and an active-low reset named arst_n in scope.
`ifndef LINE_RASTERIZER_MACROS_SVH
`define LINE_RASTERIZER_MACROS_SVH

`ifndef SYNTHESIS

// The consequent holds in the same cycle as the antecedent.
`define LR_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("line rasterizer check failed");

// The consequent holds in the cycle after the antecedent.
`define LR_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("line rasterizer check failed");

`else

`define LR_ASSERT_IMP(lbl, ante, cons)
`define LR_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

>>> src/lr_pkg.sv
package lr_pkg;

	// Screen geometry.
	localparam int SCREEN_WIDTH  = 320;
	localparam int SCREEN_HEIGHT = 240;

	// Field widths.
	localparam int X_W    = 9;
	localparam int Y_W    = 8;
	localparam int ADDR_W = 17;
	localparam int COLOR_W = 16;
	localparam int DEC_W  = 12;

	localparam logic [X_W-1:0] X_MAX = X_W'(SCREEN_WIDTH - 1);
	localparam logic [Y_W-1:0] Y_MAX = Y_W'(SCREEN_HEIGHT - 1);

	// Item action codes.
	typedef enum logic {
		ACT_LOAD = 1'b0,
		ACT_STEP = 1'b1
	} lr_action_t;

	// Per-line walk state.
	typedef struct packed {
		logic                     active;
		logic                     steep;
		logic                     dir_neg;
		logic [X_W-1:0]           cur_x;
		logic [Y_W-1:0]           cur_y;
		logic [X_W-1:0]           major_end;
		logic [X_W-1:0]           delta_major;
		logic [X_W-1:0]           delta_minor;
		logic signed [DEC_W-1:0]  decision;
		logic [COLOR_W-1:0]       color;
	} lr_line_t;

	// One emitted pixel.
	typedef struct packed {
		logic                valid;
		logic [X_W-1:0]      x;
		logic [Y_W-1:0]      y;
		logic [ADDR_W-1:0]   address;
		logic [COLOR_W-1:0]  color;
		logic                last;
	} lr_pixel_t;

endpackage

>>> src/lr_core.sv
module lr_core
	import lr_pkg::*;
(
	input  lr_line_t        line,
	input  lr_action_t      action,
	input  logic [X_W-1:0]  x_start,
	input  logic [Y_W-1:0]  y_start,
	input  logic [X_W-1:0]  x_end,
	input  logic [Y_W-1:0]  y_end,
	input  logic [COLOR_W-1:0] color,
	output lr_line_t        line_nxt,
	output lr_pixel_t       pixel
);

	logic [X_W-1:0] x0s, x1s, adx, fx, lx, major;
	logic [Y_W-1:0] y0s, y1s, ady, fy, ly;
	logic           steep_l, swap, move_minor;
	lr_line_t       walk;

	// Clamp the endpoints to the screen and measure the deltas.
	always_comb begin
		x0s = (x_start > X_MAX) ? X_MAX : x_start;
		x1s = (x_end   > X_MAX) ? X_MAX : x_end;
		y0s = (y_start > Y_MAX) ? Y_MAX : y_start;
		y1s = (y_end   > Y_MAX) ? Y_MAX : y_end;
		adx = (x0s > x1s) ? (x0s - x1s) : (x1s - x0s);
		ady = (y0s > y1s) ? (y0s - y1s) : (y1s - y0s);
		// Equal deltas take the steep case.
		steep_l = !({1'b0, ady} < adx);
		swap    = steep_l ? (y0s > y1s) : (x0s > x1s);
		fx = swap ? x1s : x0s;
		fy = swap ? y1s : y0s;
		lx = swap ? x0s : x1s;
		ly = swap ? y0s : y1s;
	end

	// Next line state: a load starts a new line, a step advances an active one.
	always_comb begin
		walk       = line;
		move_minor = line.decision > 0;
		priority if (action == ACT_LOAD) begin
			walk.active      = 1'b1;
			walk.steep       = steep_l;
			walk.dir_neg     = steep_l ? (lx < fx) : (ly < fy);
			walk.cur_x       = fx;
			walk.cur_y       = fy;
			walk.major_end   = steep_l ? {1'b0, ly} : lx;
			walk.delta_major = steep_l ? {1'b0, ady} : adx;
			walk.delta_minor = steep_l ? adx : {1'b0, ady};
			walk.decision    = $signed({2'b00, walk.delta_minor, 1'b0})
				- $signed({3'b000, walk.delta_major});
			walk.color       = color;
		end else if (line.active) begin
			if (move_minor) begin
				walk.decision = line.decision + $signed({2'b00, line.delta_minor, 1'b0})
					- $signed({2'b00, line.delta_major, 1'b0});
			end else begin
				walk.decision = line.decision + $signed({2'b00, line.delta_minor, 1'b0});
			end
			if (line.steep) begin
				walk.cur_y = line.cur_y + 1'b1;
				if (move_minor) begin
					walk.cur_x = line.dir_neg ? (line.cur_x - 1'b1) : (line.cur_x + 1'b1);
				end
			end else begin
				walk.cur_x = line.cur_x + 1'b1;
				if (move_minor) begin
					walk.cur_y = line.dir_neg ? (line.cur_y - 1'b1) : (line.cur_y + 1'b1);
				end
			end
		end else begin
			walk = line;
		end
	end

	// Emit the pixel at the new position and retire the line at its end.
	always_comb begin
		major         = walk.steep ? {1'b0, walk.cur_y} : walk.cur_x;
		pixel.valid   = (action == ACT_LOAD) || line.active;
		pixel.x       = walk.cur_x;
		pixel.y       = walk.cur_y;
		pixel.address = ADDR_W'(walk.cur_y) * ADDR_W'(SCREEN_WIDTH) + ADDR_W'(walk.cur_x);
		pixel.color   = walk.color;
		pixel.last    = (major == walk.major_end);
		line_nxt        = walk;
		line_nxt.active = walk.active && !pixel.last;
	end

endmodule

>>> src/line_rasterizer.sv
// Channel  | Direction | Handshake                 | Payload
// item     | in        | item_valid / item_stall   | action, x_start, y_start, x_end, y_end, color
// pixel    | out       | pixel_valid / pixel_stall | pixel_x, pixel_y, pixel_address,
//          |           |                           | pixel_color, last
//
// The clamp, the decision add and the address multiply by the screen width sit
// between the line state and the pixel register.
// A new item is taken in every cycle unless a held pixel is stalled.
// A load always emits a pixel; a step emits one only while a line is active.
// Reset clears the line state and empties the pixel register.
`include "line_rasterizer_macros.svh"

module line_rasterizer
	import lr_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  logic               action,
	input  logic [X_W-1:0]     x_start,
	input  logic [Y_W-1:0]     y_start,
	input  logic [X_W-1:0]     x_end,
	input  logic [Y_W-1:0]     y_end,
	input  logic [COLOR_W-1:0] color,
	output logic               pixel_valid,
	input  logic               pixel_stall,
	output logic [X_W-1:0]     pixel_x,
	output logic [Y_W-1:0]     pixel_y,
	output logic [ADDR_W-1:0]  pixel_address,
	output logic [COLOR_W-1:0] pixel_color,
	output logic               last
);

	lr_line_t  line_q, line_nxt;
	lr_pixel_t pix, pix_q;
	logic      item_acc, pix_acc;

	lr_core u_core (
		.line     (line_q),
		.action   (lr_action_t'(action)),
		.x_start  (x_start),
		.y_start  (y_start),
		.x_end    (x_end),
		.y_end    (y_end),
		.color    (color),
		.line_nxt (line_nxt),
		.pixel    (pix)
	);

	// The item side waits only while a finished pixel is held and stalled.
	assign item_stall = pix_q.valid && pixel_stall;
	assign item_acc   = item_valid && !item_stall;
	assign pix_acc    = pix_q.valid && !pixel_stall;

	// Line state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_q <= '0;
		end else if (item_acc) begin
			line_q <= line_nxt;
		end
	end

	// Pixel register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_q <= '0;
		end else if (item_acc) begin
			pix_q <= pix;
		end else if (pix_acc) begin
			pix_q.valid <= 1'b0;
		end
	end

	assign pixel_valid   = pix_q.valid;
	assign pixel_x       = pix_q.x;
	assign pixel_y       = pix_q.y;
	assign pixel_address = pix_q.address;
	assign pixel_color   = pix_q.color;
	assign last          = pix_q.last;

	// A load always produces a pixel.
	`LR_ASSERT_NXT(a_load_emits, item_acc && (action == ACT_LOAD), pixel_valid)
	// A step with no active line produces nothing.
	`LR_ASSERT_NXT(a_idle_step_silent, item_acc && (action == ACT_STEP) && !line_q.active,
		!pixel_valid)
	// A step on an active line produces a pixel.
	`LR_ASSERT_NXT(a_active_step_emits, item_acc && (action == ACT_STEP) && line_q.active,
		pixel_valid)
	// The final pixel retires the line.
	`LR_ASSERT_NXT(a_last_retires, item_acc && pix.valid && pix.last, !line_q.active)

endmodule

>>> dv/testbench.sv
module testbench
	import lr_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	// One pixel as seen on the output channel.
	typedef struct packed {
		logic [X_W-1:0]     x;
		logic [Y_W-1:0]     y;
		logic [ADDR_W-1:0]  address;
		logic [COLOR_W-1:0] color;
		logic               last;
	} pixel_t;

	// Tracks the line walk and holds the pixels still owed by the block.
	class pixel_scoreboard;
		pixel_t expected_pixels[$];
		int errors;

		bit                      active;
		bit                      steep;
		bit                      dir_neg;
		logic [X_W-1:0]          cur_x;
		logic [Y_W-1:0]          cur_y;
		logic [X_W-1:0]          major_end;
		logic [X_W-1:0]          delta_major;
		logic [X_W-1:0]          delta_minor;
		logic signed [DEC_W-1:0] decision;
		logic [COLOR_W-1:0]      line_color;

		function new();
			errors = 0;
			active = 0;
			steep = 0;
			dir_neg = 0;
			cur_x = '0;
			cur_y = '0;
			major_end = '0;
			delta_major = '0;
			delta_minor = '0;
			decision = '0;
			line_color = '0;
		endfunction

		// Queue the pixel at the current position; the end of the major range ends the line.
		function void emit_pixel();
			pixel_t p;
			logic [X_W-1:0] major;
			major = steep ? X_W'(cur_y) : cur_x;
			p.x = cur_x;
			p.y = cur_y;
			p.address = ADDR_W'(int'(cur_y) * SCREEN_WIDTH + int'(cur_x));
			p.color = line_color;
			p.last = (major == major_end);
			if (p.last)
				active = 0;
			expected_pixels.push_back(p);
		endfunction

		// Advance the line walk for one accepted item.
		function void note_item(lr_action_t act, logic [X_W-1:0] xs, logic [Y_W-1:0] ys,
				logic [X_W-1:0] xe, logic [Y_W-1:0] ye, logic [COLOR_W-1:0] c);
			logic [X_W-1:0] x0, x1, adx, tx;
			logic [Y_W-1:0] y0, y1, ady, ty;
			logic move_minor;
			if (act == ACT_LOAD) begin
				// Clamp the endpoints to the screen and pick the major axis.
				x0 = (xs > X_MAX) ? X_MAX : xs;
				y0 = (ys > Y_MAX) ? Y_MAX : ys;
				x1 = (xe > X_MAX) ? X_MAX : xe;
				y1 = (ye > Y_MAX) ? Y_MAX : ye;
				adx = (x0 > x1) ? x0 - x1 : x1 - x0;
				ady = (y0 > y1) ? y0 - y1 : y1 - y0;
				line_color = c;
				steep = !(X_W'(ady) < adx);
				if (!steep) begin
					if (x0 > x1) begin
						tx = x0; x0 = x1; x1 = tx;
						ty = y0; y0 = y1; y1 = ty;
					end
					delta_major = adx;
					delta_minor = X_W'(ady);
					dir_neg = (y1 < y0);
					major_end = x1;
				end else begin
					if (y0 > y1) begin
						tx = x0; x0 = x1; x1 = tx;
						ty = y0; y0 = y1; y1 = ty;
					end
					delta_major = X_W'(ady);
					delta_minor = adx;
					dir_neg = (x1 < x0);
					major_end = X_W'(y1);
				end
				cur_x = x0;
				cur_y = y0;
				decision = DEC_W'(2 * int'(delta_minor) - int'(delta_major));
				active = 1;
				emit_pixel();
			end else if (active) begin
				// One step along the major axis, the minor axis follows the decision term.
				move_minor = (decision > 0);
				if (move_minor)
					decision = DEC_W'(int'(decision)
						+ 2 * (int'(delta_minor) - int'(delta_major)));
				else
					decision = DEC_W'(int'(decision) + 2 * int'(delta_minor));
				if (steep) begin
					cur_y = cur_y + 1'b1;
					if (move_minor)
						cur_x = dir_neg ? cur_x - 1'b1 : cur_x + 1'b1;
				end else begin
					cur_x = cur_x + 1'b1;
					if (move_minor)
						cur_y = dir_neg ? cur_y - 1'b1 : cur_y + 1'b1;
				end
				emit_pixel();
			end
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				$display("%0t: %s expected %0d actual %0d", $time, name, want, got);
				errors++;
			end
		endfunction

		// Compare an accepted pixel with the oldest one owed.
		function void check_pixel(pixel_t got);
			pixel_t want;
			if (expected_pixels.size() == 0) begin
				$display("%0t: pixel expected none actual x=%0d y=%0d", $time, got.x, got.y);
				errors++;
				return;
			end
			want = expected_pixels.pop_front();
			compare_field("pixel_x", 32'(want.x), 32'(got.x));
			compare_field("pixel_y", 32'(want.y), 32'(got.y));
			compare_field("pixel_address", 32'(want.address), 32'(got.address));
			compare_field("pixel_color", 32'(want.color), 32'(got.color));
			compare_field("last", 32'(want.last), 32'(got.last));
		endfunction
	endclass

	logic               clk;
	logic               arst_n = 1'b0;
	logic               item_valid = 1'b0;
	logic               item_stall;
	logic               action = ACT_LOAD;
	logic [X_W-1:0]     x_start = '0;
	logic [Y_W-1:0]     y_start = '0;
	logic [X_W-1:0]     x_end = '0;
	logic [Y_W-1:0]     y_end = '0;
	logic [COLOR_W-1:0] color = '0;
	logic               pixel_valid;
	logic               pixel_stall = 1'b0;
	logic [X_W-1:0]     pixel_x;
	logic [Y_W-1:0]     pixel_y;
	logic [ADDR_W-1:0]  pixel_address;
	logic [COLOR_W-1:0] pixel_color;
	logic               last;

	pixel_scoreboard sb;
	int idle_pct = 37;
	int counted_items = 0;

	line_rasterizer uut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.action(action),
		.x_start(x_start),
		.y_start(y_start),
		.x_end(x_end),
		.y_end(y_end),
		.color(color),
		.pixel_valid(pixel_valid),
		.pixel_stall(pixel_stall),
		.pixel_x(pixel_x),
		.pixel_y(pixel_y),
		.pixel_address(pixel_address),
		.pixel_color(pixel_color),
		.last(last)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Pixel side: take a pixel whenever valid and not stalled, then pick the next stall.
	always @(posedge clk) begin
		if (arst_n && pixel_valid && !pixel_stall)
			sb.check_pixel('{pixel_x, pixel_y, pixel_address, pixel_color, last});
		pixel_stall <= ($urandom_range(99) < idle_pct);
	end

	// Offer one item after a random gap and hold it until the block takes it.
	task automatic send_item(lr_action_t act, logic [X_W-1:0] xs, logic [Y_W-1:0] ys,
			logic [X_W-1:0] xe, logic [Y_W-1:0] ye, logic [COLOR_W-1:0] c);
		while ($urandom_range(99) < idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		action <= act;
		x_start <= xs;
		y_start <= ys;
		x_end <= xe;
		y_end <= ye;
		color <= c;
		do
			@(posedge clk);
		while (item_stall !== 1'b0);
		if (act == ACT_LOAD || sb.active)
			counted_items++;
		sb.note_item(act, xs, ys, xe, ye, c);
	endtask

	// A step carries random coordinates and color that the block must ignore.
	task automatic step_item();
		send_item(ACT_STEP, X_W'($urandom_range(511)), Y_W'($urandom_range(255)),
			X_W'($urandom_range(511)), Y_W'($urandom_range(255)), COLOR_W'($urandom));
	endtask

	task automatic draw_line(logic [X_W-1:0] xs, logic [Y_W-1:0] ys, logic [X_W-1:0] xe,
			logic [Y_W-1:0] ye, logic [COLOR_W-1:0] c, int steps);
		send_item(ACT_LOAD, xs, ys, xe, ye, c);
		repeat (steps)
			step_item();
	endtask

	// Hold the item side until every owed pixel has come out.
	task automatic drain_pixels();
		item_valid <= 1'b0;
		@(posedge clk);
		while (sb.expected_pixels.size() != 0)
			@(posedge clk);
	endtask

	// Mostly short lines walked to the end, some long ones, some cut short or overrun.
	task automatic random_lines(int target);
		logic [X_W-1:0] xs, xe;
		logic [Y_W-1:0] ys, ye;
		int offset;
		int ext;
		int start_count;
		bit drained;
		start_count = counted_items;
		drained = 0;
		while (counted_items - start_count < target) begin
			ext = counted_items - start_count;
			idle_pct = (ext >= 500 && ext < 800) ? 0 : 37;
			if (!drained && ext >= 1200) begin
				drain_pixels();
				drained = 1;
			end
			if ($urandom_range(24) == 0) begin
				xs = X_W'($urandom_range(511));
				ys = Y_W'($urandom_range(255));
				xe = X_W'($urandom_range(511));
				ye = Y_W'($urandom_range(255));
			end else begin
				xs = X_W'(($urandom_range(9) == 0) ? $urandom_range(511) : $urandom_range(319));
				ys = Y_W'(($urandom_range(9) == 0) ? $urandom_range(255) : $urandom_range(239));
				offset = int'(xs) + int'($urandom_range(30)) - 15;
				xe = X_W'((offset < 0) ? 0 : (offset > 511) ? 511 : offset);
				offset = int'(ys) + int'($urandom_range(30)) - 15;
				ye = Y_W'((offset < 0) ? 0 : (offset > 255) ? 255 : offset);
				if ($urandom_range(19) == 0) begin
					xe = xs;
					ye = ys;
				end
			end
			send_item(ACT_LOAD, xs, ys, xe, ye, COLOR_W'($urandom));
			while (sb.active) begin
				if ($urandom_range(29) == 0)
					break;
				step_item();
			end
			if ($urandom_range(4) == 0)
				repeat ($urandom_range(1, 3))
					step_item();
		end
	endtask

	initial begin
		sb = new();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed lines: no line yet, single pixel, clamped shallow, steep, diagonal,
		// shallow going up, and a long line cut short by the next load.
		step_item();
		draw_line(9'd5, 8'd5, 9'd5, 8'd5, 16'h0000, 1);
		draw_line(9'd511, 8'd255, 9'd316, 8'd239, 16'hFFFF, 3);
		draw_line(9'd0, 8'd0, 9'd2, 8'd5, 16'h1234, 5);
		draw_line(9'd3, 8'd0, 9'd0, 8'd3, 16'hA5A5, 3);
		draw_line(9'd0, 8'd5, 9'd4, 8'd3, 16'h5A5A, 4);
		draw_line(9'd0, 8'd0, 9'd511, 8'd255, 16'h8000, 2);
		drain_pixels();

		random_lines(1950);

		// Let the last pixels out, then let the clock run on before the verdict.
		drain_pixels();
		repeat (20) @(posedge clk);
		if (sb.errors == 0 && sb.expected_pixels.size() == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("testbench: FAIL");
		$finish;
	end
endmodule
